### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sprite entry tile expander.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a in this cycle implies c in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// a in this cycle implies c in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)

`endif

`endif

### hw/rtl/setx_pkg.sv
// Package of the sprite entry tile expander: field widths, controller states
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package setx_pkg;

    localparam int TILE_W  = 16;
    localparam int COLOR_W = 6;
    localparam int SIZE_W  = 3;
    localparam int POS_W   = 14;
    localparam int CPOS_W  = 15;
    localparam int CELL_SH = 4;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_setx_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_setx_cmd;

    typedef struct packed {
        logic in_tile_zero;
        logic at_last;
        logic out_free;
    } t_setx_sts;

endpackage

### hw/rtl/sprite_entry_tile_expander.sv
// Top level of the sprite entry tile expander: controller plus datapath.
// Depends on setx_pkg, setx_ctrl, setx_dpath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One sprite entry (attr and pos words) is taken per input beat while the
// block is idle. An entry with a zero start tile yields no output and the
// block stays ready. Otherwise it emits width*height cell beats, 1 to 64,
// column-major, one per cycle when the output is not stalled; the controller
// steps the cell counters of the datapath whenever the output register is
// free, so any output stall holds the block busy for longer.
// The next entry is taken the cycle after the final cell is loaded
// into the output register, even while that beat still waits to be taken.
// The last beat has o_last_cell set.
module sprite_entry_tile_expander
    import setx_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [31:0]              i_attr_word,
    input  logic [31:0]              i_pos_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [TILE_W-1:0]        o_cell_tile,
    output logic [COLOR_W-1:0]       o_cell_color,
    output logic signed [CPOS_W-1:0] o_cell_x,
    output logic signed [CPOS_W-1:0] o_cell_y,
    output logic                     o_last_cell
);

    t_setx_cmd   w_cmd;
    t_setx_sts   w_sts;
    t_setx_state w_state;

    logic w_in_beat;
    logic w_in_blank;
    logic w_last_step;
    logic w_marked_out;

    setx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    setx_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr_word  (i_attr_word),
        .i_pos_word   (i_pos_word),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_cell_tile  (o_cell_tile),
        .o_cell_color (o_cell_color),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_last_cell  (o_last_cell)
    );

    assign w_in_beat    = i_in_valid && !o_in_stall;
    assign w_in_blank   = (i_attr_word[31:16] == '0);
    assign w_last_step  = w_cmd.step && w_sts.at_last;
    assign w_marked_out = o_out_valid && o_last_cell;

    // accepted entry with a nonzero tile starts expansion
    `ASSERT_NEXT(a_start_run, i_clk, i_rst_n, w_in_beat && !w_in_blank, w_state == S_RUN)
    // entry with a zero tile leaves the block idle
    `ASSERT_NEXT(a_zero_idle, i_clk, i_rst_n, w_in_beat && w_in_blank, w_state == S_IDLE)
    // final cell step returns to idle with a marked beat on the output
    `ASSERT_NEXT(a_last_beat, i_clk, i_rst_n, w_last_step, (w_state == S_IDLE) && w_marked_out)
    // cells are stepped only while running
    `ASSERT_SAME(a_step_run, i_clk, i_rst_n, w_cmd.step, w_state == S_RUN)

endmodule

### hw/rtl/setx_ctrl.sv
// Controller of the sprite entry tile expander: idle/run state machine.
// Depends on setx_pkg.
`timescale 1ns / 1ps

module setx_ctrl
    import setx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_setx_sts   i_sts,
    output t_setx_cmd   o_cmd,
    output t_setx_state o_state
);

    t_setx_state r_state;
    t_setx_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_tile_zero) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.at_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

### hw/rtl/setx_dpath.sv
// Datapath of the sprite entry tile expander: entry registers, cell counters
// and the output register. Depends on setx_pkg.
`timescale 1ns / 1ps

module setx_dpath
    import setx_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [31:0]              i_attr_word,
    input  logic [31:0]              i_pos_word,
    input  t_setx_cmd                i_cmd,
    output t_setx_sts                o_sts,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [TILE_W-1:0]        o_cell_tile,
    output logic [COLOR_W-1:0]       o_cell_color,
    output logic signed [CPOS_W-1:0] o_cell_x,
    output logic signed [CPOS_W-1:0] o_cell_y,
    output logic                     o_last_cell
);

    logic [TILE_W-1:0]  r_tile;
    logic [COLOR_W-1:0] r_color;
    logic [SIZE_W-1:0]  r_wm1;
    logic [SIZE_W-1:0]  r_hm1;
    logic [SIZE_W-1:0]  r_col;
    logic [SIZE_W-1:0]  r_row;
    logic [POS_W-1:0]   r_xpos;
    logic [POS_W-1:0]   r_ypos;

    logic                     r_out_valid;
    logic [TILE_W-1:0]        r_out_tile;
    logic [COLOR_W-1:0]       r_out_color;
    logic [CPOS_W-1:0]        r_out_x;
    logic [CPOS_W-1:0]        r_out_y;
    logic                     r_out_last;

    logic              w_row_end;
    logic              w_col_end;
    logic [CPOS_W-1:0] w_x;
    logic [CPOS_W-1:0] w_y;

    assign w_row_end = (r_row == r_hm1);
    assign w_col_end = (r_col == r_wm1);

    // sign-extended position plus 16 * offset
    assign w_x = {r_xpos[POS_W-1], r_xpos}
               + {{(CPOS_W-SIZE_W-CELL_SH){1'b0}}, r_col, {CELL_SH{1'b0}}};
    assign w_y = {r_ypos[POS_W-1], r_ypos}
               + {{(CPOS_W-SIZE_W-CELL_SH){1'b0}}, r_row, {CELL_SH{1'b0}}};

    assign o_sts.in_tile_zero = (i_attr_word[31:16] == '0);
    assign o_sts.at_last      = w_row_end && w_col_end;
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tile  <= i_attr_word[31:16];
            r_color <= i_attr_word[5:0];
            r_wm1   <= i_attr_word[10:8];
            r_hm1   <= i_attr_word[14:12];
            r_xpos  <= i_pos_word[13:0];
            r_ypos  <= i_pos_word[29:16];
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cmd.step) begin
            r_tile <= r_tile + 1'b1;
            if (w_row_end) begin
                r_row <= '0;
                r_col <= r_col + 1'b1;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_tile  <= r_tile;
            r_out_color <= r_color;
            r_out_x     <= w_x;
            r_out_y     <= w_y;
            r_out_last  <= w_row_end && w_col_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_tile  = r_out_tile;
    assign o_cell_color = r_out_color;
    assign o_cell_x     = r_out_x;
    assign o_cell_y     = r_out_y;
    assign o_last_cell  = r_out_last;

endmodule
